>>> hw/rtl/assert_macros.svh
// Assertion macros for the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/edcd_pkg.sv
// Package: constants, types and register codes of the density collapse detector
package edcd_pkg;

  localparam int BATCH_SIZE = 4;
  localparam int GRID_COLS  = 16;
  localparam int GRID_ROWS  = 14;
  localparam int CELL_SHIFT = 3;

  localparam int NCELLS  = GRID_COLS * GRID_ROWS;
  localparam int ADDR_W  = $clog2(NCELLS);
  localparam int BATCH_W = (BATCH_SIZE > 1) ? $clog2(BATCH_SIZE) : 1;
  localparam int COORD_W = 7;
  localparam int CCORD_W = COORD_W - CELL_SHIFT;
  localparam int CELL_W  = 4;
  localparam int DENS_W  = 8;
  localparam int SH_W    = 3;
  localparam int STR_W   = 5;

  localparam logic [ADDR_W-1:0]  LAST_ADDR  = ADDR_W'(NCELLS - 1);
  localparam logic [BATCH_W-1:0] LAST_EVENT = BATCH_W'(BATCH_SIZE - 1);
  localparam logic [CCORD_W-1:0] MAX_COL    = CCORD_W'(GRID_COLS - 1);
  localparam logic [CCORD_W-1:0] MAX_ROW    = CCORD_W'(GRID_ROWS - 1);
  localparam logic [CELL_W-1:0]  LAST_COL   = CELL_W'(GRID_COLS - 1);
  localparam logic [DENS_W-1:0]  DENSITY_MAX  = 8'd255;
  localparam logic [STR_W-1:0]   STRENGTH_MAX = 5'd31;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_STEP_SIZE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY_INTERVAL = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FAST_LEAK      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CHASE_UP       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CHASE_DOWN     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_COLLAPSE_THR   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_BASELINE_FLOOR = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_STRENGTH_SHIFT = 3'd7;

  localparam logic [DENS_W-1:0] RST_STEP_SIZE      = 8'd128;
  localparam logic [DENS_W-1:0] RST_DECAY_INTERVAL = 8'd8;
  localparam logic [SH_W-1:0]   RST_FAST_LEAK      = 3'd3;
  localparam logic [SH_W-1:0]   RST_CHASE_UP       = 3'd1;
  localparam logic [SH_W-1:0]   RST_CHASE_DOWN     = 3'd5;
  localparam logic [DENS_W-1:0] RST_COLLAPSE_THR   = 8'd48;
  localparam logic [DENS_W-1:0] RST_BASELINE_FLOOR = 8'd64;
  localparam logic [SH_W-1:0]   RST_STRENGTH_SHIFT = 3'd3;

  typedef enum logic [1:0] {
    OP_SCAN  = 2'd0,
    OP_EVENT = 2'd1,
    OP_DECAY = 2'd2
  } alu_op_t;

  typedef struct packed {
    logic [DENS_W-1:0] step;
    logic [SH_W-1:0]   leak_sh;
    logic [SH_W-1:0]   up_sh;
    logic [SH_W-1:0]   dn_sh;
  } alu_cfg_t;

  typedef struct packed {
    logic [DENS_W-1:0] slow;
    logic [DENS_W-1:0] fast;
  } cell_word_t;

  typedef struct packed {
    cell_word_t        word;
    logic [DENS_W-1:0] gap;
  } cell_res_t;

endpackage

>>> hw/rtl/edcd_in_if.sv
// Event input channel: valid/ready with pixel coordinates
interface edcd_in_if;
  logic                        valid;
  logic                        ready;
  logic [edcd_pkg::COORD_W-1:0] event_x;
  logic [edcd_pkg::COORD_W-1:0] event_y;

  modport source (output valid, output event_x, output event_y, input ready);
  modport sink   (input valid, input event_x, input event_y, output ready);
endinterface

>>> hw/rtl/edcd_out_if.sv
// Result channel: valid/ready with collapse cell, strength and flag
interface edcd_out_if;
  logic                        valid;
  logic                        ready;
  logic [edcd_pkg::CELL_W-1:0] cell_col;
  logic [edcd_pkg::CELL_W-1:0] cell_row;
  logic [edcd_pkg::STR_W-1:0]  strength;
  logic                        black_hole;

  modport source (output valid, output cell_col, output cell_row, output strength,
                  output black_hole, input ready);
  modport sink   (input valid, input cell_col, input cell_row, input strength,
                  input black_hole, output ready);
endinterface

>>> hw/rtl/edcd_mem.sv
// Density memory: fast and slow density per cell, one write and one registered read
module edcd_mem (
  input  logic                          clk,
  input  logic                          we,
  input  logic [edcd_pkg::ADDR_W-1:0]   waddr,
  input  edcd_pkg::cell_word_t          wdata,
  input  logic [edcd_pkg::ADDR_W-1:0]   raddr,
  output edcd_pkg::cell_word_t          rdata
);

  edcd_pkg::cell_word_t mem_r [edcd_pkg::NCELLS];
  edcd_pkg::cell_word_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> hw/rtl/edcd_alu.sv
// Shared cell unit: event add, leak/chase update, and slow-minus-fast gap
module edcd_alu (
  input  edcd_pkg::alu_op_t    op,
  input  edcd_pkg::alu_cfg_t   cfg,
  input  edcd_pkg::cell_word_t cur,
  output edcd_pkg::cell_res_t  res
);

  always_comb begin
    logic [edcd_pkg::DENS_W:0]   sum;
    logic [edcd_pkg::DENS_W-1:0] fl;
    logic [edcd_pkg::DENS_W-1:0] f_n;
    logic [edcd_pkg::DENS_W-1:0] s_n;

    sum = {1'b0, cur.fast} + {1'b0, cfg.step};
    fl  = cur.fast - (cur.fast >> cfg.leak_sh);

    case (op)
      edcd_pkg::OP_EVENT: begin
        f_n = sum[edcd_pkg::DENS_W] ? edcd_pkg::DENSITY_MAX : sum[edcd_pkg::DENS_W-1:0];
        s_n = cur.slow;
      end
      edcd_pkg::OP_DECAY: begin
        f_n = fl;
        if (fl > cur.slow) begin
          s_n = cur.slow + ((fl - cur.slow) >> cfg.up_sh);
        end else begin
          s_n = cur.slow - ((cur.slow - fl) >> cfg.dn_sh);
        end
      end
      default: begin
        f_n = cur.fast;
        s_n = cur.slow;
      end
    endcase

    res.word.fast = f_n;
    res.word.slow = s_n;
    res.gap       = (s_n > f_n) ? (s_n - f_n) : '0;
  end

endmodule

>>> hw/rtl/event_density_collapse_detector.sv
// Top level: event density collapse detector with a sequenced sweep over the cell memory
//
//   channel   dir  handshake          payload
//   in_ev     in   valid/ready        event_x[6:0], event_y[6:0]
//   out_res   out  valid/ready        cell_col[3:0], cell_row[3:0], strength[4:0], black_hole
//   cfg_*     in   cfg_we (no wait)   cfg_idx[2:0], cfg_wdata[7:0]
//
// Sequence: an event that does not close a batch is handled as a read, then a
// read-modify-write of its cell. The event that closes a batch adds a sweep of
// all 224 cells of the memory plus drain and emit, in a batch of 4 events; the
// single memory read port sets the length of the sweep.
// Reset: synchronous; afterwards a clearing pass zeroes all 224 cells of the memory,
// with in_ev.ready low. Config writes are taken at any time.
// Stalls: a pending result blocks only the emit step; events are taken while
// an earlier result still waits in the output register.
`include "assert_macros.svh"

module event_density_collapse_detector (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [edcd_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  logic [edcd_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  edcd_in_if.sink                            in_ev,
  edcd_out_if.source                         out_res
);

  // sequencer states
  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,   // clearing pass after reset
    S_IDLE  = 6'b000010,   // waiting for an event; read of its cell issued on transfer
    S_EVWR  = 6'b000100,   // event add written back
    S_SWEEP = 6'b001000,   // one cell read per cycle
    S_DRAIN = 6'b010000,   // last cell processed
    S_EMIT  = 6'b100000    // load result register
  } state_t;

  state_t state_r, state_nxt;

  // configuration registers
  logic [edcd_pkg::DENS_W-1:0] step_size_r;
  logic [edcd_pkg::DENS_W-1:0] decay_interval_r;
  logic [edcd_pkg::SH_W-1:0]   fast_leak_shift_r;
  logic [edcd_pkg::SH_W-1:0]   chase_up_shift_r;
  logic [edcd_pkg::SH_W-1:0]   chase_down_shift_r;
  logic [edcd_pkg::DENS_W-1:0] collapse_threshold_r;
  logic [edcd_pkg::DENS_W-1:0] baseline_floor_r;
  logic [edcd_pkg::SH_W-1:0]   strength_shift_r;

  // batch bookkeeping
  logic [edcd_pkg::BATCH_W-1:0] ev_cnt_r;
  logic                         ev_last_r;
  logic [edcd_pkg::DENS_W-1:0]  ticks_r;
  logic [edcd_pkg::DENS_W-1:0]  ticks_inc;
  logic                         decay_r;

  // event cell address
  logic [edcd_pkg::CCORD_W-1:0] ev_col, ev_row;
  logic [edcd_pkg::ADDR_W-1:0]  ev_addr, ev_addr_r;

  // sweep pipeline
  logic [edcd_pkg::ADDR_W-1:0] sw_addr_r;
  logic                        pv_r;
  logic [edcd_pkg::ADDR_W-1:0] p_addr_r;
  logic [edcd_pkg::CELL_W-1:0] p_col_r, p_row_r;

  // best cell so far
  logic [edcd_pkg::CELL_W-1:0] best_col_r, best_row_r;
  logic [edcd_pkg::DENS_W-1:0] best_gap_r, lead_slow_r;

  // result register
  logic                        out_valid_r;
  logic [edcd_pkg::CELL_W-1:0] out_col_r, out_row_r;
  logic [edcd_pkg::STR_W-1:0]  out_str_r;
  logic                        out_flag_r;
  logic [edcd_pkg::DENS_W-1:0] gap_sh;
  logic [edcd_pkg::STR_W-1:0]  strength;
  logic                        flag;
  logic                        emit_go;

  // memory and shared unit
  logic                        mem_we;
  logic [edcd_pkg::ADDR_W-1:0] mem_waddr, mem_raddr;
  edcd_pkg::cell_word_t        mem_wdata, mem_rdata;
  edcd_pkg::alu_op_t           alu_op;
  edcd_pkg::alu_cfg_t          alu_cfg;
  edcd_pkg::cell_res_t         alu_res;

  logic in_xfer, out_xfer;

  assign in_ev.ready = (state_r == S_IDLE);
  assign in_xfer     = in_ev.valid && in_ev.ready;
  assign out_xfer    = out_valid_r && out_res.ready;
  assign emit_go     = (state_r == S_EMIT) && (!out_valid_r || out_res.ready);

  // coarse cell of the event, clamped to the grid
  always_comb begin
    ev_col = in_ev.event_x[edcd_pkg::COORD_W-1:edcd_pkg::CELL_SHIFT];
    ev_row = in_ev.event_y[edcd_pkg::COORD_W-1:edcd_pkg::CELL_SHIFT];
    if (ev_col > edcd_pkg::MAX_COL) begin
      ev_col = edcd_pkg::MAX_COL;
    end
    if (ev_row > edcd_pkg::MAX_ROW) begin
      ev_row = edcd_pkg::MAX_ROW;
    end
    ev_addr = edcd_pkg::ADDR_W'(edcd_pkg::ADDR_W'(ev_row) *
                                edcd_pkg::ADDR_W'(edcd_pkg::GRID_COLS))
              + edcd_pkg::ADDR_W'(ev_col);
  end

  assign ticks_inc = ticks_r + 1'b1;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        if (sw_addr_r == edcd_pkg::LAST_ADDR) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_xfer) begin
          state_nxt = S_EVWR;
        end
      end
      S_EVWR: begin
        state_nxt = ev_last_r ? S_SWEEP : S_IDLE;
      end
      S_SWEEP: begin
        if (sw_addr_r == edcd_pkg::LAST_ADDR) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (emit_go) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  // memory port and shared unit steering
  always_comb begin
    mem_raddr = (state_r == S_IDLE) ? ev_addr : sw_addr_r;
    alu_op    = edcd_pkg::OP_SCAN;
    case (state_r)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = sw_addr_r;
        mem_wdata = '0;
      end
      S_EVWR: begin
        alu_op    = edcd_pkg::OP_EVENT;
        mem_we    = 1'b1;
        mem_waddr = ev_addr_r;
        mem_wdata = alu_res.word;
      end
      default: begin
        // sweep write-back only on decay batches
        if (pv_r && decay_r) begin
          alu_op = edcd_pkg::OP_DECAY;
        end
        mem_we    = pv_r && decay_r;
        mem_waddr = p_addr_r;
        mem_wdata = alu_res.word;
      end
    endcase
  end

  assign alu_cfg.step    = step_size_r;
  assign alu_cfg.leak_sh = fast_leak_shift_r;
  assign alu_cfg.up_sh   = chase_up_shift_r;
  assign alu_cfg.dn_sh   = chase_down_shift_r;

  edcd_mem u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  edcd_alu u_alu (
    .op  (alu_op),
    .cfg (alu_cfg),
    .cur (mem_rdata),
    .res (alu_res)
  );

  // result fields from the best cell
  always_comb begin
    gap_sh   = best_gap_r >> strength_shift_r;
    strength = (gap_sh > edcd_pkg::DENS_W'(edcd_pkg::STRENGTH_MAX))
               ? edcd_pkg::STRENGTH_MAX : gap_sh[edcd_pkg::STR_W-1:0];
    flag     = (best_gap_r >= collapse_threshold_r) && (lead_slow_r >= baseline_floor_r);
  end

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_size_r          <= edcd_pkg::RST_STEP_SIZE;
      decay_interval_r     <= edcd_pkg::RST_DECAY_INTERVAL;
      fast_leak_shift_r    <= edcd_pkg::RST_FAST_LEAK;
      chase_up_shift_r     <= edcd_pkg::RST_CHASE_UP;
      chase_down_shift_r   <= edcd_pkg::RST_CHASE_DOWN;
      collapse_threshold_r <= edcd_pkg::RST_COLLAPSE_THR;
      baseline_floor_r     <= edcd_pkg::RST_BASELINE_FLOOR;
      strength_shift_r     <= edcd_pkg::RST_STRENGTH_SHIFT;
    end else if (cfg_we) begin
      case (cfg_idx)
        edcd_pkg::REG_STEP_SIZE:      step_size_r          <= cfg_wdata;
        edcd_pkg::REG_DECAY_INTERVAL: decay_interval_r     <= cfg_wdata;
        edcd_pkg::REG_FAST_LEAK:      fast_leak_shift_r    <= cfg_wdata[edcd_pkg::SH_W-1:0];
        edcd_pkg::REG_CHASE_UP:       chase_up_shift_r     <= cfg_wdata[edcd_pkg::SH_W-1:0];
        edcd_pkg::REG_CHASE_DOWN:     chase_down_shift_r   <= cfg_wdata[edcd_pkg::SH_W-1:0];
        edcd_pkg::REG_COLLAPSE_THR:   collapse_threshold_r <= cfg_wdata;
        edcd_pkg::REG_BASELINE_FLOOR: baseline_floor_r     <= cfg_wdata;
        edcd_pkg::REG_STRENGTH_SHIFT: strength_shift_r     <= cfg_wdata[edcd_pkg::SH_W-1:0];
        default: ;
      endcase
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      sw_addr_r   <= '0;
      pv_r        <= 1'b0;
      ev_cnt_r    <= '0;
      ev_last_r   <= 1'b0;
      ticks_r     <= '0;
      decay_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pv_r    <= (state_r == S_SWEEP);

      case (state_r)
        S_CLEAR, S_SWEEP: begin
          sw_addr_r <= (sw_addr_r == edcd_pkg::LAST_ADDR) ? '0 : sw_addr_r + 1'b1;
        end
        S_EVWR: begin
          sw_addr_r <= '0;
          if (ev_last_r) begin
            // batch closed: tick, and decide whether this sweep decays
            if (ticks_inc >= decay_interval_r) begin
              ticks_r <= '0;
              decay_r <= 1'b1;
            end else begin
              ticks_r <= ticks_inc;
              decay_r <= 1'b0;
            end
          end
        end
        default: ;
      endcase

      if (in_xfer) begin
        ev_last_r <= (ev_cnt_r == edcd_pkg::LAST_EVENT);
        ev_cnt_r  <= (ev_cnt_r == edcd_pkg::LAST_EVENT) ? '0 : ev_cnt_r + 1'b1;
      end

      if (emit_go) begin
        out_valid_r <= 1'b1;
      end else if (out_xfer) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload: event address, sweep pipeline, best cell, result
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      ev_addr_r <= ev_addr;
    end
    p_addr_r <= sw_addr_r;

    if (state_r == S_EVWR) begin
      p_col_r     <= '0;
      p_row_r     <= '0;
      best_col_r  <= '0;
      best_row_r  <= '0;
      best_gap_r  <= '0;
      lead_slow_r <= '0;
    end else if (pv_r) begin
      // strict compare keeps the first cell in row-major order
      if (alu_res.gap > best_gap_r) begin
        best_gap_r  <= alu_res.gap;
        lead_slow_r <= alu_res.word.slow;
        best_col_r  <= p_col_r;
        best_row_r  <= p_row_r;
      end
      if (p_col_r == edcd_pkg::LAST_COL) begin
        p_col_r <= '0;
        p_row_r <= p_row_r + 1'b1;
      end else begin
        p_col_r <= p_col_r + 1'b1;
      end
    end

    if (emit_go) begin
      out_col_r  <= best_col_r;
      out_row_r  <= best_row_r;
      out_str_r  <= strength;
      out_flag_r <= flag;
    end
  end

  assign out_res.valid      = out_valid_r;
  assign out_res.cell_col   = out_col_r;
  assign out_res.cell_row   = out_row_r;
  assign out_res.strength   = out_str_r;
  assign out_res.black_hole = out_flag_r;

  // checks
  `ASSERT_SAME(a_rise_from_emit, $rose(out_valid_r), $past(state_r == S_EMIT), "result without emit")
  `ASSERT_SAME(a_no_take_in_sweep, pv_r, !in_ev.ready, "event taken during sweep")
  `ASSERT_SAME(a_sweep_rw_apart, mem_we && (state_r == S_SWEEP), mem_waddr != mem_raddr, "sweep write hits read address")
  `ASSERT_NEXT(a_drain_to_emit, state_r == S_DRAIN, state_r == S_EMIT && !pv_r, "drain not followed by emit")

endmodule
